// ===== rtl/core/vector3_normalize_macros.svh =====
// Assertion macros for the vector normalizer RTL.
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define V3N_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define V3N_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/v3n_pkg.sv =====
// Shared types and constants of the vector normalizer.
package v3n_pkg;

  localparam int unsigned Lanes     = 3;
  localparam int unsigned MagW      = 30;
  localparam int unsigned SqW       = 2 * MagW;
  localparam int unsigned SumW      = SqW + 2;
  localparam int unsigned RadW      = 64;
  localparam int unsigned RootW     = 32;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned QuotW     = 31;
  localparam int unsigned DivSteps  = QuotW;
  localparam int unsigned TargetMsb = 29;

  localparam logic [QuotW-1:0] OneQ30 = QuotW'(1) << 30;

  typedef logic [MagW-1:0] mag_t;

  typedef struct packed {
    mag_t [Lanes-1:0] mag;
    logic [Lanes-1:0] neg;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic en;
    logic valid;
  } flow_t;

endpackage

// ===== rtl/core/v3n_prep.sv =====
// Magnitude, alignment shift, squares and sum of squares (three stages).
module v3n_prep (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  v3n_pkg::flow_t          flow_i,
  input  logic signed [31:0]      comp_x_i,
  input  logic signed [31:0]      comp_y_i,
  input  logic signed [31:0]      comp_z_i,
  output logic                    valid_o,
  output logic [v3n_pkg::RadW-1:0] rad_o,
  output v3n_pkg::side_t          side_o
);
  import v3n_pkg::*;

  logic [Lanes-1:0][31:0] raw;
  logic [Lanes-1:0][31:0] mag;
  logic [Lanes-1:0]       neg;
  logic [31:0]            mmax;
  logic [4:0]             pos;
  side_t                  side_d;

  logic                   valid_a_q, valid_b_q, valid_c_q;
  side_t                  side_a_q, side_b_q, side_c_q;
  logic [Lanes-1:0][SqW-1:0] sq_q;
  logic [SumW-1:0]        sum_q;

  assign raw = {comp_z_i, comp_y_i, comp_x_i};

  always_comb begin
    mmax = '0;
    pos  = '0;
    for (int l = 0; l < Lanes; l++) begin
      neg[l] = raw[l][31];
      mag[l] = raw[l][31] ? (32'd0 - raw[l]) : raw[l];
      if (mag[l] > mmax) begin
        mmax = mag[l];
      end
    end
    for (int b = 0; b < 32; b++) begin
      if (mmax[b]) begin
        pos = 5'(b);
      end
    end
    for (int l = 0; l < Lanes; l++) begin
      if (pos >= 5'(TargetMsb)) begin
        side_d.mag[l] = MagW'(mag[l] >> (pos - 5'(TargetMsb)));
      end else begin
        side_d.mag[l] = MagW'(mag[l] << (5'(TargetMsb) - pos));
      end
    end
    side_d.neg  = neg;
    side_d.zero = (mmax == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (flow_i.en) begin
      valid_a_q <= flow_i.valid;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.en) begin
      side_a_q <= side_d;
      side_b_q <= side_a_q;
      side_c_q <= side_b_q;
      for (int l = 0; l < Lanes; l++) begin
        sq_q[l] <= SqW'(side_a_q.mag[l]) * SqW'(side_a_q.mag[l]);
      end
      sum_q <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
    end
  end

  assign valid_o = valid_c_q;
  assign rad_o   = {sum_q, 2'b00};
  assign side_o  = side_c_q;

endmodule

// ===== rtl/core/v3n_sqrt.sv =====
// Integer square root, one result bit per pipeline stage.
module v3n_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [v3n_pkg::RadW-1:0]  rad_i,
  input  v3n_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [v3n_pkg::RootW-1:0] root_o,
  output v3n_pkg::side_t            side_o
);
  import v3n_pkg::*;

  logic [RadW-1:0] n_q   [SqrtSteps];
  logic [RadW-1:0] res_q [SqrtSteps];
  side_t           side_q[SqrtSteps];
  logic            val_q [SqrtSteps];

  logic [RadW-1:0] n_d   [SqrtSteps];
  logic [RadW-1:0] res_d [SqrtSteps];

  always_comb begin
    logic [RadW-1:0] sn, sr, trial, bitv;
    for (int j = 0; j < SqrtSteps; j++) begin
      sn    = (j == 0) ? rad_i : n_q[(j == 0) ? 0 : j - 1];
      sr    = (j == 0) ? '0 : res_q[(j == 0) ? 0 : j - 1];
      bitv  = RadW'(1) << (RadW - 2 - 2 * j);
      trial = sr + bitv;
      if (sn >= trial) begin
        n_d[j]   = sn - trial;
        res_d[j] = (sr >> 1) + bitv;
      end else begin
        n_d[j]   = sn;
        res_d[j] = sr >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SqrtSteps; j++) begin
        val_q[j] <= 1'b0;
      end
    end else if (en_i) begin
      val_q[0] <= valid_i;
      for (int j = 1; j < SqrtSteps; j++) begin
        val_q[j] <= val_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int j = 0; j < SqrtSteps; j++) begin
        n_q[j]   <= n_d[j];
        res_q[j] <= res_d[j];
      end
      for (int j = 1; j < SqrtSteps; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign valid_o = val_q[SqrtSteps-1];
  assign root_o  = RootW'(res_q[SqrtSteps-1]);
  assign side_o  = side_q[SqrtSteps-1];

endmodule

// ===== rtl/core/v3n_div.sv =====
// Rounded division of each magnitude by the root, one quotient bit per stage.
module v3n_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [v3n_pkg::RootW-1:0] root_i,
  input  v3n_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic signed [31:0]        unit_x_o,
  output logic signed [31:0]        unit_y_o,
  output logic signed [31:0]        unit_z_o,
  output logic                      zero_length_o
);
  import v3n_pkg::*;

  localparam int unsigned Stages = DivSteps + 1;

  logic [Lanes-1:0][RootW-1:0] rem_q [Stages];
  logic [Lanes-1:0][QuotW-1:0] quo_q [Stages];
  logic [Lanes-1:0][QuotW-1:0] low_q [Stages];
  logic [RootW-1:0]            root_q[Stages];
  side_t                       side_q[Stages];
  logic                        val_q [Stages];

  logic [Lanes-1:0][RootW-1:0] rem_d [DivSteps];
  logic [Lanes-1:0][QuotW-1:0] quo_d [DivSteps];
  logic [Lanes-1:0][61:0]      num;
  logic [Lanes-1:0][31:0]      res_d;
  logic                        val_out_q;
  logic [Lanes-1:0][31:0]      unit_q;
  logic                        zero_q;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      num[l] = {side_i.mag[l], 31'd0} + 62'(root_i >> 1);
    end
  end

  always_comb begin
    logic [RootW:0] r33;
    logic           ge;
    for (int k = 1; k < Stages; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        r33 = {rem_q[k-1][l], low_q[k-1][l][5'(DivSteps - k)]};
        ge  = (r33 >= {1'b0, root_q[k-1]});
        rem_d[k-1][l] = ge ? RootW'(r33 - {1'b0, root_q[k-1]}) : r33[RootW-1:0];
        quo_d[k-1][l] = {quo_q[k-1][l][QuotW-2:0], ge};
      end
    end
  end

  always_comb begin
    logic [QuotW-1:0] qs;
    for (int l = 0; l < Lanes; l++) begin
      qs = (quo_q[Stages-1][l] > OneQ30) ? OneQ30 : quo_q[Stages-1][l];
      if (side_q[Stages-1].zero) begin
        res_d[l] = '0;
      end else if (side_q[Stages-1].neg[l]) begin
        res_d[l] = 32'd0 - 32'(qs);
      end else begin
        res_d[l] = 32'(qs);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Stages; k++) begin
        val_q[k] <= 1'b0;
      end
      val_out_q <= 1'b0;
    end else if (en_i) begin
      val_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        val_q[k] <= val_q[k-1];
      end
      val_out_q <= val_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q[0] <= root_i;
      side_q[0] <= side_i;
      for (int l = 0; l < Lanes; l++) begin
        rem_q[0][l] <= RootW'(num[l][61:31]);
        low_q[0][l] <= num[l][30:0];
        quo_q[0][l] <= '0;
      end
      for (int k = 1; k < Stages; k++) begin
        root_q[k] <= root_q[k-1];
        side_q[k] <= side_q[k-1];
        low_q[k]  <= low_q[k-1];
        rem_q[k]  <= rem_d[k-1];
        quo_q[k]  <= quo_d[k-1];
      end
      unit_q <= res_d;
      zero_q <= side_q[Stages-1].zero;
    end
  end

  assign valid_o       = val_out_q;
  assign unit_x_o      = unit_q[0];
  assign unit_y_o      = unit_q[1];
  assign unit_z_o      = unit_q[2];
  assign zero_length_o = zero_q;

endmodule

// ===== rtl/core/vector3_normalize.sv =====
// Top level of the pipelined three-element vector normalizer.
//
// Each input transaction carries one row (comp_x_i, comp_y_i, comp_z_i) in
// signed Q8.24. The matching output transaction carries the row scaled to
// unit length in signed Q2.30, rounded to nearest, plus zero_length_o,
// which is set with all-zero elements when the input row was all zeros.
// Both channels use valid and stall; a transaction completes on a clock
// edge with valid high and stall low.
// A row passes through the alignment and sum-of-squares stages, the
// one-bit-per-stage square root, the per-element dividers and the
// output register. One row can enter every cycle while stall_o is low.
// An output stall with valid_o high freezes every stage, and stall_o
// follows it in the same cycle, so nothing is dropped or repeated.
// Reset clears every valid bit; the pipeline then holds no transaction.
module vector3_normalize (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] comp_x_i,
  input  logic signed [31:0] comp_y_i,
  input  logic signed [31:0] comp_z_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] unit_x_o,
  output logic signed [31:0] unit_y_o,
  output logic signed [31:0] unit_z_o,
  output logic               zero_length_o
);
  import v3n_pkg::*;

  `include "vector3_normalize_macros.svh"

  flow_t            flow;
  logic             prep_valid, sqrt_valid;
  logic [RadW-1:0]  rad;
  logic [RootW-1:0] root;
  side_t            prep_side, sqrt_side;
  logic             units_zero, x_in_range, y_in_range;

  assign flow    = '{en: !(valid_o && stall_i), valid: valid_i};
  assign stall_o = valid_o && stall_i;

  v3n_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .flow_i   (flow),
    .comp_x_i (comp_x_i),
    .comp_y_i (comp_y_i),
    .comp_z_i (comp_z_i),
    .valid_o  (prep_valid),
    .rad_o    (rad),
    .side_o   (prep_side)
  );

  v3n_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (flow.en),
    .valid_i (prep_valid),
    .rad_i   (rad),
    .side_i  (prep_side),
    .valid_o (sqrt_valid),
    .root_o  (root),
    .side_o  (sqrt_side)
  );

  v3n_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (flow.en),
    .valid_i       (sqrt_valid),
    .root_i        (root),
    .side_i        (sqrt_side),
    .valid_o       (valid_o),
    .unit_x_o      (unit_x_o),
    .unit_y_o      (unit_y_o),
    .unit_z_o      (unit_z_o),
    .zero_length_o (zero_length_o)
  );

  assign units_zero = (unit_x_o == 32'sd0) && (unit_y_o == 32'sd0) && (unit_z_o == 32'sd0);
  assign x_in_range = (unit_x_o <= 32'sd1073741824) && (unit_x_o >= -32'sd1073741824);
  assign y_in_range = (unit_y_o <= 32'sd1073741824) && (unit_y_o >= -32'sd1073741824);

  `V3N_ASSERT_IMP(a_zero_row, valid_o && zero_length_o, units_zero, "Zero row gave nonzero elements.")
  `V3N_ASSERT(a_x_range, !valid_o || x_in_range, "unit_x_o out of range.")
  `V3N_ASSERT(a_y_range, !valid_o || y_in_range, "unit_y_o out of range.")

endmodule
